### hw/rtl/pdg_pkg.sv
// Shared types and constants for the pairwise difference block.
package pdg_pkg;

    localparam int MASK_W    = 64;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int SUM_OUT_W = 42;
    localparam int MIN_W     = 32;
    localparam int MEAN_W    = 48;
    localparam int Q_FRAC    = 16;
    localparam int POP_LIMIT = 4;
    localparam int MEMBER_REGS = 4;

    localparam logic [63:0] SUM_MAX = 64'h0000_03FF_FFFF_FFFF;

    typedef logic [1:0] func_t;
    localparam func_t FUNC_UPDATE = 2'd0;
    localparam func_t FUNC_REPORT = 2'd1;
    localparam func_t FUNC_CLEAR  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_SAMPLE_COUNT = 3'd0;
    localparam reg_idx_t REG_POP_COUNT    = 3'd1;
    localparam reg_idx_t REG_MEMBERS0     = 3'd2;
    localparam reg_idx_t REG_MEMBERS1     = 3'd3;
    localparam reg_idx_t REG_MEMBERS2     = 3'd4;
    localparam reg_idx_t REG_MEMBERS3     = 3'd5;

    typedef logic [1:0] pop_idx_t;

    typedef struct packed {
        func_t              func;
        logic [MASK_W-1:0]  covered_mask;
        logic [MASK_W-1:0]  derived_mask;
    } in_word_t;

    typedef struct packed {
        pop_idx_t              first_pop;
        pop_idx_t              second_pop;
        logic [SUM_OUT_W-1:0]  diff_sum;
        logic [MIN_W-1:0]      min_diff;
        logic [MEAN_W-1:0]     mean_diff_q16;
        logic                  last;
    } out_word_t;

    typedef struct packed {
        logic site_load;
        logic rd_en;
        logic rd_upd;
        logic rd_acc;
        logic clr_wr;
        logic pair_start;
        logic div_start;
        logic out_load;
        logic out_last;
    } cmd_t;

    typedef struct packed {
        logic       acc_busy;
        logic       div_done;
        logic       out_free;
        logic [2:0] pops_used;
    } stat_t;

endpackage

### hw/rtl/pdg_div.sv
// Restoring divider, one quotient bit per cycle.
module pdg_div #(
    parameter int DVD_W = 60,
    parameter int DVS_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    // Trial subtract of the shifted remainder
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        ge      = rem_sh >= {1'b0, dvs_reg};
    end

    // Control: count steps, flag completion
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: shift in one quotient bit per step
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### hw/rtl/pdg_datapath.sv
// Datapath: configuration, counter memory, reduction tree, divider, output register.
module pdg_datapath
    import pdg_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int COUNT_BITS  = 32,
    parameter int ROW_AW      = 6,
    parameter int N_W         = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    input  logic [ROW_AW-1:0]     row,
    input  pop_idx_t              pi,
    input  pop_idx_t              pj,
    input  in_word_t              s_data,
    input  logic                  cfg_wr_en,
    input  reg_idx_t              cfg_index,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output out_word_t             m_data,
    output stat_t                 stat,
    output logic [N_W-1:0]        n_used
);

    localparam int ROW_W  = MAX_SAMPLES * COUNT_BITS;
    localparam int LEVELS = $clog2(MAX_SAMPLES);
    localparam int TREE_N = 1 << LEVELS;
    localparam int PAIR_W = $clog2(MAX_SAMPLES * (MAX_SAMPLES - 1) + 1);
    localparam int SUM_W  = COUNT_BITS + PAIR_W;
    localparam int DVD_W  = SUM_W + Q_FRAC;

    // Configuration registers
    logic [6:0]        sample_count_reg;
    logic [2:0]        pop_count_reg;
    logic [MASK_W-1:0] members_reg [MEMBER_REGS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= 7'd64;
            pop_count_reg    <= 3'd2;
            for (int k = 0; k < MEMBER_REGS; k++) begin
                members_reg[k] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_wr_data[6:0];
                REG_POP_COUNT:    pop_count_reg    <= cfg_wr_data[2:0];
                REG_MEMBERS0:     members_reg[0]   <= cfg_wr_data;
                REG_MEMBERS1:     members_reg[1]   <= cfg_wr_data;
                REG_MEMBERS2:     members_reg[2]   <= cfg_wr_data;
                REG_MEMBERS3:     members_reg[3]   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic [2:0]        pops_used;
    logic [MASK_W-1:0] use_mask;

    // Clamp counts and build the in-use sample mask
    always_comb begin
        n_used = (sample_count_reg > 7'(MAX_SAMPLES)) ? N_W'(MAX_SAMPLES)
                                                       : N_W'(sample_count_reg);
        pops_used = (pop_count_reg > 3'(POP_LIMIT)) ? 3'(POP_LIMIT) : pop_count_reg;
        for (int k = 0; k < MASK_W; k++) begin
            use_mask[k] = 7'(k) < 7'(n_used);
        end
    end

    // Site masks and population masks of the pair under report
    logic [MASK_W-1:0] cov_reg, der_reg, mi_reg, mj_reg;

    always_ff @(posedge aclk) begin
        if (cmd.site_load) begin
            cov_reg <= s_data.covered_mask;
            der_reg <= s_data.derived_mask;
        end
        if (cmd.pair_start) begin
            mi_reg <= members_reg[pi] & use_mask;
            mj_reg <= members_reg[pj] & use_mask;
        end
    end

    // Counter memory: row a holds the counters of pairs (a, b), b > a
    logic [ROW_W-1:0]  mem [MAX_SAMPLES];
    logic [ROW_W-1:0]  rd_data_reg;
    logic [ROW_AW-1:0] rd_row_reg;
    logic              rd_upd_reg, rd_acc_reg;
    logic [ROW_W-1:0]  upd_row;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_row;
    logic [ROW_W-1:0]  wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_upd_reg <= 1'b0;
            rd_acc_reg <= 1'b0;
        end else begin
            rd_upd_reg <= cmd.rd_en & cmd.rd_upd;
            rd_acc_reg <= cmd.rd_en & cmd.rd_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[row];
            rd_row_reg  <= row;
        end
    end

    // Increment every counter of the row whose pair differs at this site
    always_comb begin
        logic [COUNT_BITS-1:0] c;
        logic                  inc;
        for (int b = 0; b < MAX_SAMPLES; b++) begin
            c   = rd_data_reg[b*COUNT_BITS +: COUNT_BITS];
            inc = cov_reg[rd_row_reg] & cov_reg[b] & (der_reg[rd_row_reg] ^ der_reg[b])
                  & (ROW_AW'(b) > rd_row_reg) & use_mask[b];
            upd_row[b*COUNT_BITS +: COUNT_BITS] = (inc && c != '1) ? c + COUNT_BITS'(1) : c;
        end
        wr_en   = rd_upd_reg | cmd.clr_wr;
        wr_row  = cmd.clr_wr ? row : rd_row_reg;
        wr_data = cmd.clr_wr ? '0 : upd_row;
    end

    // Registered reduction tree over the lanes of one row
    logic [SUM_W-1:0]  t_sum [LEVELS+1][TREE_N];
    logic [PAIR_W-1:0] t_pr  [LEVELS+1][TREE_N];
    logic [MIN_W-1:0]  t_min [LEVELS+1][TREE_N];
    logic [LEVELS:0]   vld_reg;

    always_ff @(posedge aclk) begin
        logic [COUNT_BITS-1:0] c;
        logic [1:0]            w;
        for (int b = 0; b < TREE_N; b++) begin
            if (b < MAX_SAMPLES) begin
                c = rd_data_reg[b*COUNT_BITS +: COUNT_BITS];
                w = (ROW_AW'(b) > rd_row_reg)
                    ? {1'b0, mi_reg[rd_row_reg] & mj_reg[b]}
                      + {1'b0, mj_reg[rd_row_reg] & mi_reg[b]}
                    : 2'd0;
                t_sum[0][b] <= (w == 2'd2) ? (SUM_W'(c) << 1)
                             : (w == 2'd1) ? SUM_W'(c) : '0;
                t_pr[0][b]  <= PAIR_W'(w);
                t_min[0][b] <= (w != 2'd0) ? MIN_W'(c) : '1;
            end else begin
                t_sum[0][b] <= '0;
                t_pr[0][b]  <= '0;
                t_min[0][b] <= '1;
            end
        end
        for (int l = 1; l <= LEVELS; l++) begin
            for (int k = 0; k < (TREE_N >> l); k++) begin
                t_sum[l][k] <= t_sum[l-1][2*k] + t_sum[l-1][2*k+1];
                t_pr[l][k]  <= t_pr[l-1][2*k] + t_pr[l-1][2*k+1];
                t_min[l][k] <= (t_min[l-1][2*k] < t_min[l-1][2*k+1])
                               ? t_min[l-1][2*k] : t_min[l-1][2*k+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[LEVELS-1:0], rd_acc_reg};
        end
    end

    // Accumulate row results for the current population pair
    logic [SUM_W-1:0]  sum_acc_reg;
    logic [PAIR_W-1:0] pairs_acc_reg;
    logic [MIN_W-1:0]  min_acc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.pair_start) begin
            sum_acc_reg   <= '0;
            pairs_acc_reg <= '0;
            min_acc_reg   <= '1;
        end else if (vld_reg[LEVELS]) begin
            sum_acc_reg   <= sum_acc_reg + t_sum[LEVELS][0];
            pairs_acc_reg <= pairs_acc_reg + t_pr[LEVELS][0];
            if (t_min[LEVELS][0] < min_acc_reg) begin
                min_acc_reg <= t_min[LEVELS][0];
            end
        end
    end

    // Mean: sum scaled to Q16 over the pair count
    logic [DVD_W-1:0] quotient;
    logic             div_done;

    pdg_div #(
        .DVD_W (DVD_W),
        .DVS_W (PAIR_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({sum_acc_reg, Q_FRAC'(0)}),
        .divisor  (pairs_acc_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Output register
    logic      m_valid_reg;
    out_word_t m_data_reg;
    logic [63:0] sum64;
    logic        out_free;

    assign sum64    = 64'(sum_acc_reg);
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.first_pop     <= pi;
            m_data_reg.second_pop    <= pj;
            m_data_reg.diff_sum      <= (sum64 > SUM_MAX) ? '1 : sum64[SUM_OUT_W-1:0];
            m_data_reg.min_diff      <= min_acc_reg;
            m_data_reg.mean_diff_q16 <= (pairs_acc_reg == '0) ? '0 : MEAN_W'(quotient);
            m_data_reg.last          <= cmd.out_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign stat.acc_busy  = rd_acc_reg | (|vld_reg);
    assign stat.div_done  = div_done;
    assign stat.out_free  = out_free;
    assign stat.pops_used = pops_used;

endmodule

### hw/rtl/pdg_ctrl.sv
// Controller: sequences row sweeps for update, clear and report.
module pdg_ctrl
    import pdg_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int ROW_AW      = 6,
    parameter int N_W         = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  func_t             s_func,
    input  stat_t             stat,
    input  logic [N_W-1:0]    n_used,
    output logic              s_ready,
    output cmd_t              cmd,
    output logic [ROW_AW-1:0] row,
    output pop_idx_t          pi,
    output pop_idx_t          pj
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_UPD    = 7'b0000010,
        ST_CLR    = 7'b0000100,
        ST_PSTART = 7'b0001000,
        ST_PREAD  = 7'b0010000,
        ST_PDRAIN = 7'b0100000,
        ST_PDIV   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_AW-1:0] row_reg, row_next;
    pop_idx_t          pi_reg, pi_next, pj_reg, pj_next;

    logic n_ok, row_end, last_pair;

    always_comb begin
        n_ok      = n_used >= N_W'(2);
        row_end   = ((N_W+1)'(row_reg) + (N_W+1)'(2)) == (N_W+1)'(n_used);
        last_pair = ({1'b0, pi_reg} + 3'd2 == stat.pops_used)
                    && ({1'b0, pj_reg} + 3'd1 == stat.pops_used);
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        pi_next    = pi_reg;
        pj_next    = pj_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.site_load = 1'b1;
                    row_next      = '0;
                    case (s_func)
                        FUNC_UPDATE: begin
                            if (n_ok) state_next = ST_UPD;
                        end
                        FUNC_CLEAR: begin
                            state_next = ST_CLR;
                        end
                        FUNC_REPORT: begin
                            if (stat.pops_used >= 3'd2) begin
                                pi_next    = 2'd0;
                                pj_next    = 2'd1;
                                state_next = ST_PSTART;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_UPD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_upd = 1'b1;
                if (row_end) state_next = ST_IDLE;
                else row_next = row_reg + ROW_AW'(1);
            end
            ST_CLR: begin
                cmd.clr_wr = 1'b1;
                if (row_reg == ROW_AW'(MAX_SAMPLES - 1)) state_next = ST_IDLE;
                else row_next = row_reg + ROW_AW'(1);
            end
            ST_PSTART: begin
                cmd.pair_start = 1'b1;
                row_next       = '0;
                state_next     = n_ok ? ST_PREAD : ST_PDRAIN;
            end
            ST_PREAD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_acc = 1'b1;
                if (row_end) state_next = ST_PDRAIN;
                else row_next = row_reg + ROW_AW'(1);
            end
            ST_PDRAIN: begin
                if (!stat.acc_busy) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_PDIV;
                end
            end
            ST_PDIV: begin
                if (stat.div_done && stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = last_pair;
                    if ({1'b0, pj_reg} + 3'd1 < stat.pops_used) begin
                        pj_next    = pj_reg + 2'd1;
                        state_next = ST_PSTART;
                    end else if ({1'b0, pi_reg} + 3'd2 < stat.pops_used) begin
                        pi_next    = pi_reg + 2'd1;
                        pj_next    = pi_reg + 2'd2;
                        state_next = ST_PSTART;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Reset starts with a clearing sweep of the counter memory
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            row_reg   <= '0;
            pi_reg    <= '0;
            pj_reg    <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            pi_reg    <= pi_next;
            pj_reg    <= pj_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign row     = row_reg;
    assign pi      = pi_reg;
    assign pj      = pj_reg;

endmodule

### hw/rtl/pairwise_difference_gmin.sv
// Top level: pairwise difference counters with population-pair report.
//
// Input words (s_valid/s_ready, s_data) carry a command: site update, report
// or clear. A site update sweeps rows 0 to n - 2 of the counter memory, one
// row per cycle for n samples in use, with a read-modify-write of each row.
// A clear sweeps all MAX_SAMPLES rows, one per cycle.
// A report yields one output word per population pair (m_valid/m_ready,
// m_data), last set on the final pair. Each pair takes about n - 1 row reads,
// a pass through the reduction tree, and the bit-serial divider for the
// mean. One command is worked on at a time; s_ready is high only when idle.
// A finished word waits in the output register while the next pair is
// computed; if the receiver stalls, the block holds before loading the next.
// After reset the counter memory is cleared in a pass over all MAX_SAMPLES
// rows with s_ready low; configuration writes are taken throughout.
module pairwise_difference_gmin
    import pdg_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int COUNT_BITS  = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_word_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_word_t        m_data,
    input  logic             cfg_wr_en,
    input  reg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int ROW_AW = $clog2(MAX_SAMPLES);
    localparam int N_W    = $clog2(MAX_SAMPLES + 1);

    cmd_t              cmd;
    stat_t             stat;
    logic [ROW_AW-1:0] row;
    pop_idx_t          pi, pj;
    logic [N_W-1:0]    n_used;

    pdg_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .ROW_AW      (ROW_AW),
        .N_W         (N_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_data.func),
        .stat    (stat),
        .n_used  (n_used),
        .s_ready (s_ready),
        .cmd     (cmd),
        .row     (row),
        .pi      (pi),
        .pj      (pj)
    );

    pdg_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .COUNT_BITS  (COUNT_BITS),
        .ROW_AW      (ROW_AW),
        .N_W         (N_W)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .row         (row),
        .pi          (pi),
        .pj          (pj),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .stat        (stat),
        .n_used      (n_used)
    );

endmodule

### hw/rtl/pdg_checker.sv
// Port-level checks for the pairwise difference block, bound to the top level.
module pdg_checker
    import pdg_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Reset starts the clearing pass, so no input word is taken
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input accepted straight after reset");

    // Pairs are reported with the lower population first
    a_pop_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.first_pop < m_data.second_pop)
        else $error("population pair out of order");

    // A zero sum gives a zero mean
    a_mean_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.diff_sum == '0 |-> m_data.mean_diff_q16 == '0)
        else $error("mean nonzero with zero sum");

    // A real minimum never exceeds the sum
    a_min_le_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.min_diff != 32'hFFFF_FFFF
            |-> m_data.diff_sum >= {10'd0, m_data.min_diff})
        else $error("minimum above sum");

endmodule

bind pairwise_difference_gmin pdg_checker u_pdg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
